// ===== src/mbg_pkg.sv =====
// Package for the main board I/O and interrupt glue.
// Holds the action codes, I/O page constants, vectors and the shared
// item, state and result types. No dependencies.
`default_nettype none

package mbg_pkg;

   // Access or event carried by one input transfer.
   typedef enum logic [2:0] {
      ACT_MEM_RD = 3'd0,
      ACT_IO_WR  = 3'd1,
      ACT_IO_RD  = 3'd2,
      ACT_IRQ    = 3'd3,
      ACT_ACK    = 3'd4,
      ACT_SUB    = 3'd5
   } act_type;

   // I/O space is decoded in 32-byte pages.
   localparam logic [15:0] PAGE_MASK  = 16'hffe0;
   localparam logic [15:0] PAGE_SLOT0 = 16'hff00;
   localparam logic [15:0] PAGE_SLOT1 = 16'hff20;
   localparam logic [15:0] PAGE_SLOT2 = 16'hff40;
   localparam logic [15:0] PAGE_SLOT3 = 16'hff60;
   localparam logic [15:0] PAGE_MASKS = 16'hff80;
   localparam logic [15:0] PAGE_MAP   = 16'hffa0;
   localparam logic [15:0] PAGE_COMM  = 16'hffc0;
   localparam logic [15:0] PAGE_IGN   = 16'hffe0;

   // Highest memory address served by ROM while it is mapped.
   localparam logic [15:0] ROM_TOP = 16'h8fff;

   // Interrupt sources; request and mask bits: S is bit 4, A..D are bits 0..3.
   localparam int unsigned NUM_SRC = 5;
   localparam logic [2:0] SRC_S = 3'd0;
   localparam logic [2:0] SRC_A = 3'd1;
   localparam logic [2:0] SRC_B = 3'd2;
   localparam logic [2:0] SRC_C = 3'd3;
   localparam logic [2:0] SRC_D = 3'd4;

   // Acknowledge vectors.
   localparam logic [7:0] VEC_S    = 8'hf0;
   localparam logic [7:0] VEC_A    = 8'hf2;
   localparam logic [7:0] VEC_B    = 8'hf4;
   localparam logic [7:0] VEC_C    = 8'hf6;
   localparam logic [7:0] VEC_D    = 8'hf8;
   localparam logic [7:0] VEC_NONE = 8'hff;

   typedef struct packed {
      logic [2:0]  action;
      logic [15:0] address;
      logic [7:0]  data;
      logic [2:0]  line_index;
      logic        line_level;
   } item_type;

   typedef struct packed {
      logic [2:0] slot_select;
      logic       rom_mapped;
      logic [4:0] irq_mask_bits;
      logic       sub_int2_mask;
      logic [4:0] irq_pending;
      logic [7:0] sub_byte;
   } state_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       rom_selected;
      logic       slot_forward;
      logic [2:0] slot_index;
      logic       sub_int2_update;
      logic       sub_int2_level;
      logic       sub_comm_valid;
      logic       irq_line;
   } result_type;

   // Bit of the request and mask registers that belongs to a source.
   function automatic logic [4:0] src_bit(input logic [2:0] idx);
      logic [4:0] b;
      b = '0;
      case (idx)
         SRC_S:   b = 5'b10000;
         SRC_A:   b = 5'b00001;
         SRC_B:   b = 5'b00010;
         SRC_C:   b = 5'b00100;
         SRC_D:   b = 5'b01000;
         default: b = '0;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

// ===== src/mbg_decode.sv =====
// Single-pass decode for one item of the main board glue.
// Computes the result and the next board state from the held item and
// the current state. Depends on mbg_pkg.
`default_nettype none

module mbg_decode (
   input  mbg_pkg::item_type   item,
   input  mbg_pkg::state_type  cur_state,
   output mbg_pkg::result_type result,
   output mbg_pkg::state_type  nxt_state
);
   import mbg_pkg::*;

   logic [15:0] page;
   logic [4:0]  hit;

   assign page = item.address & PAGE_MASK;
   assign hit  = cur_state.irq_pending & cur_state.irq_mask_bits;

   // Decode the access and apply its side effects.
   always_comb begin
      nxt_state = cur_state;
      result    = '0;
      case (item.action)
         ACT_MEM_RD: begin
            result.rom_selected = cur_state.rom_mapped && (item.address <= ROM_TOP);
         end
         ACT_IO_WR: begin
            if (page inside {PAGE_SLOT0, PAGE_SLOT1, PAGE_SLOT2, PAGE_SLOT3}) begin
               nxt_state.slot_select[2:1] = item.data[1:0];
            end else if (page == PAGE_MASKS) begin
               nxt_state.sub_int2_mask = item.data[7];
               result.sub_int2_update  = item.data[7] != cur_state.sub_int2_mask;
               nxt_state.irq_mask_bits = item.data[4:0];
            end else if (page == PAGE_MAP) begin
               nxt_state.rom_mapped     = ~item.data[1];
               nxt_state.slot_select[0] = item.data[0];
            end else if (page == PAGE_COMM) begin
               result.sub_comm_valid = 1'b1;
            end else if (page == PAGE_IGN) begin
               result.sub_comm_valid = 1'b0;
            end else begin
               result.slot_forward = 1'b1;
            end
         end
         ACT_IO_RD: begin
            if (page inside {PAGE_MASKS, PAGE_MAP, PAGE_COMM, PAGE_IGN}) begin
               result.read_data = cur_state.sub_byte;
            end else begin
               result.slot_forward = 1'b1;
            end
         end
         ACT_IRQ: begin
            // An index beyond D gives an all-zero bit, so nothing changes.
            if (item.line_level) begin
               nxt_state.irq_pending = cur_state.irq_pending | src_bit(item.line_index);
            end else begin
               nxt_state.irq_pending = cur_state.irq_pending & ~src_bit(item.line_index);
            end
         end
         ACT_ACK: begin
            // Fixed priority S, A, B, C, D; the winner's request is cleared.
            if (hit[4]) begin
               result.read_data         = VEC_S;
               nxt_state.irq_pending[4] = 1'b0;
            end else if (hit[0]) begin
               result.read_data         = VEC_A;
               nxt_state.irq_pending[0] = 1'b0;
            end else if (hit[1]) begin
               result.read_data         = VEC_B;
               nxt_state.irq_pending[1] = 1'b0;
            end else if (hit[2]) begin
               result.read_data         = VEC_C;
               nxt_state.irq_pending[2] = 1'b0;
            end else if (hit[3]) begin
               result.read_data         = VEC_D;
               nxt_state.irq_pending[3] = 1'b0;
            end else begin
               result.read_data = VEC_NONE;
            end
         end
         ACT_SUB: begin
            nxt_state.sub_byte = item.data;
         end
         default: begin
            result = '0;
         end
      endcase

      // Status reflects the state after this item.
      result.slot_index     = nxt_state.slot_select;
      result.sub_int2_level = nxt_state.sub_int2_mask;
      result.irq_line       = |(nxt_state.irq_pending & nxt_state.irq_mask_bits);
   end

endmodule

`default_nettype wire

// ===== src/main_board_io_and_interrupt_glue.sv =====
// Top level of the main board I/O and interrupt glue.
// Input register, decode stage (mbg_decode) and result register.
// Depends on mbg_pkg and mbg_decode.
//
// Usage: each req_ transfer carries one bus access or event (memory read,
// I/O write, I/O read, interrupt line level, interrupt acknowledge, byte
// from the sub processor). Each one yields exactly one rsp_ transfer with
// the decode results, the acknowledge vector or sub byte on rsp_read_data,
// the slot selection, the sub INT2 mask bit and the CPU interrupt line.
// Each item is held in the input register, passes through the decode logic
// into the result register, and rsp_valid rises when it is loaded. Board
// state is updated when an item moves into the result register, so items
// take effect strictly in order. The block takes one item per cycle while
// the receiver does not stall.
// When the receiver stalls, the result register holds its item, the input
// register fills, and req_ready falls; nothing is lost or repeated.
// A synchronous reset empties both registers and sets the board state to
// slot 0, ROM mapped, all masks and requests clear and sub byte zero.
`default_nettype none

module main_board_io_and_interrupt_glue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [2:0]  req_line_index,
   input  logic        req_line_level,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_read_data,
   output logic        rsp_rom_selected,
   output logic        rsp_slot_forward,
   output logic [2:0]  rsp_slot_index,
   output logic        rsp_sub_int2_update,
   output logic        rsp_sub_int2_level,
   output logic        rsp_sub_comm_valid,
   output logic        rsp_irq_line
);
   import mbg_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   item_ff, item_in;
   logic       out_valid_ff, out_valid_in;
   result_type res_ff, res_in;
   state_type  state_ff, state_in;
   result_type dec_result;
   state_type  dec_state;
   logic       advance;
   logic       take_req;

   // Handshake: the decode stage moves when the result register is free.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take_req  = req_valid && req_ready;

   mbg_decode u_decode (
      .item      (item_ff),
      .cur_state (state_ff),
      .result    (dec_result),
      .nxt_state (dec_state)
   );

   // Next values of the pipeline and state registers.
   always_comb begin
      in_valid_in  = take_req || (in_valid_ff && !advance);
      item_in      = item_ff;
      if (take_req) begin
         item_in.action     = req_action;
         item_in.address    = req_address;
         item_in.data       = req_data;
         item_in.line_index = req_line_index;
         item_in.line_level = req_line_level;
      end
      out_valid_in = advance || (out_valid_ff && !rsp_ready);
      res_in       = advance ? dec_result : res_ff;
      state_in     = advance ? dec_state : state_ff;
   end

   // Control and board state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         out_valid_ff           <= 1'b0;
         state_ff.slot_select   <= '0;
         state_ff.rom_mapped    <= 1'b1;
         state_ff.irq_mask_bits <= '0;
         state_ff.sub_int2_mask <= 1'b0;
         state_ff.irq_pending   <= '0;
         state_ff.sub_byte      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_read_data       = res_ff.read_data;
   assign rsp_rom_selected    = res_ff.rom_selected;
   assign rsp_slot_forward    = res_ff.slot_forward;
   assign rsp_slot_index      = res_ff.slot_index;
   assign rsp_sub_int2_update = res_ff.sub_int2_update;
   assign rsp_sub_int2_level  = res_ff.sub_int2_level;
   assign rsp_sub_comm_valid  = res_ff.sub_comm_valid;
   assign rsp_irq_line        = res_ff.irq_line;

`ifndef ASSERT_OFF
   // Reset empties both pipeline registers.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

   // A freshly loaded result reports the interrupt line of the updated state.
   a_irq_line_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_irq_line == (|(state_ff.irq_pending & state_ff.irq_mask_bits)))
      else $error("interrupt line does not match board state");

   // A freshly loaded result reports the updated slot selection.
   a_slot_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_slot_index == state_ff.slot_select)
      else $error("slot index does not match board state");

   // A held item that cannot move stays in the input register unchanged.
   a_item_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("stalled item lost or changed");

   // Board state changes only when an item moves into the result register.
   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("board state changed without an item");
`endif

endmodule

`default_nettype wire

// ===== tb/board_glue_checker.sv =====
// Checker for the main board I/O and interrupt glue: watches both channels,
// keeps its own copy of the board state and compares every result transfer.
// Depends on mbg_pkg for the item, state and result types and the decode constants.
module board_glue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [2:0]  req_line_index,
   input  logic        req_line_level,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [7:0]  rsp_read_data,
   input  logic        rsp_rom_selected,
   input  logic        rsp_slot_forward,
   input  logic [2:0]  rsp_slot_index,
   input  logic        rsp_sub_int2_update,
   input  logic        rsp_sub_int2_level,
   input  logic        rsp_sub_comm_valid,
   input  logic        rsp_irq_line,
   output int          fail_count,
   output int          results_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import mbg_pkg::*;

   // Only the first failures are printed; all of them are counted.
   localparam int PRINT_LIMIT = 40;

   state_type  board;
   result_type predicted_results[$];
   int         errors = 0;
   int         results_seen = 0;

   task automatic report_failure(input string msg);
      if (errors < PRINT_LIMIT) begin
         $display("ERROR at %0t: %s", $realtime, msg);
      end
      errors++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want) begin
         report_failure($sformatf("result %0d: %s is 0x%0h, predicted 0x%0h",
                                  results_seen, name, got, want));
      end
   endtask

   // Request and mask bit of an interrupt source: S sits at bit 4, A..D at bits 0..3.
   function automatic logic [4:0] source_flag(input int s);
      return (s == SRC_S) ? 5'b10000 : 5'(1 << (s - 1));
   endfunction

   // Applies one access or event to the board copy and returns its decode.
   function automatic result_type advance_board(input item_type it);
      result_type r;
      logic [15:0] page;
      logic [4:0]  armed;
      logic        granted;
      int          s;
      r = '0;
      page = it.address & PAGE_MASK;
      case (it.action)
         ACT_MEM_RD: begin
            r.rom_selected = board.rom_mapped && (it.address <= ROM_TOP);
         end
         ACT_IO_WR: begin
            case (page)
               PAGE_SLOT0, PAGE_SLOT1, PAGE_SLOT2, PAGE_SLOT3: begin
                  board.slot_select[2:1] = it.data[1:0];
               end
               PAGE_MASKS: begin
                  r.sub_int2_update = (it.data[7] != board.sub_int2_mask);
                  board.sub_int2_mask = it.data[7];
                  board.irq_mask_bits = it.data[4:0];
               end
               PAGE_MAP: begin
                  board.rom_mapped = !it.data[1];
                  board.slot_select[0] = it.data[0];
               end
               PAGE_COMM: r.sub_comm_valid = 1'b1;
               PAGE_IGN: ;
               default: r.slot_forward = 1'b1;
            endcase
         end
         ACT_IO_RD: begin
            case (page)
               PAGE_MASKS, PAGE_MAP, PAGE_COMM, PAGE_IGN: r.read_data = board.sub_byte;
               default: r.slot_forward = 1'b1;
            endcase
         end
         ACT_IRQ: begin
            // Source numbers past D leave the request latch alone.
            if (it.line_index < NUM_SRC) begin
               if (it.line_level) begin
                  board.irq_pending |= source_flag(it.line_index);
               end else begin
                  board.irq_pending &= ~source_flag(it.line_index);
               end
            end
         end
         ACT_ACK: begin
            // Fixed priority S, A, B, C, D; the winner's request is cleared.
            r.read_data = VEC_NONE;
            armed = board.irq_pending & board.irq_mask_bits;
            granted = 1'b0;
            for (s = 0; s < NUM_SRC; s++) begin
               if (!granted && (armed & source_flag(s)) != '0) begin
                  granted = 1'b1;
                  board.irq_pending &= ~source_flag(s);
                  r.read_data = VEC_S + 8'(2 * s);
               end
            end
         end
         ACT_SUB: board.sub_byte = it.data;
         default: ;
      endcase
      r.slot_index = board.slot_select;
      r.sub_int2_level = board.sub_int2_mask;
      r.irq_line = |(board.irq_pending & board.irq_mask_bits);
      return r;
   endfunction

   // Compare each result transfer with the oldest prediction, then predict
   // for the request transfer of the same edge.
   always @(posedge clock) begin
      item_type   taken;
      result_type got;
      result_type want;
      if (reset) begin
         predicted_results.delete();
         board = '0;
         board.rom_mapped = 1'b1;
      end else begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            got = {rsp_read_data, rsp_rom_selected, rsp_slot_forward, rsp_slot_index,
                   rsp_sub_int2_update, rsp_sub_int2_level, rsp_sub_comm_valid,
                   rsp_irq_line};
            if (predicted_results.size() == 0) begin
               report_failure($sformatf("result %0d arrived with none predicted",
                                        results_seen));
            end else begin
               want = predicted_results.pop_front();
               check_field("read_data", got.read_data, want.read_data);
               check_field("rom_selected", got.rom_selected, want.rom_selected);
               check_field("slot_forward", got.slot_forward, want.slot_forward);
               check_field("slot_index", got.slot_index, want.slot_index);
               check_field("sub_int2_update", got.sub_int2_update, want.sub_int2_update);
               check_field("sub_int2_level", got.sub_int2_level, want.sub_int2_level);
               check_field("sub_comm_valid", got.sub_comm_valid, want.sub_comm_valid);
               check_field("irq_line", got.irq_line, want.irq_line);
            end
         end
         if (req_valid && req_ready) begin
            taken = {req_action, req_address, req_data, req_line_index, req_line_level};
            predicted_results.push_back(advance_board(taken));
         end
      end
      fail_count <= errors;
      results_owed <= predicted_results.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for the main board I/O and interrupt glue: clock,
// reset, directed and random bus traffic, receiver stalls and the verdict.
// Depends on mbg_pkg, the glue top level and board_glue_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbg_pkg::*;

   // Action codes the block leaves undefined, and a source number past D.
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam logic [2:0] SRC_BEYOND   = 3'd7;

   localparam int RANDOM_PER_PHASE = 375;
   localparam int HOLD_CYCLES      = 300;
   localparam int DRAIN_LIMIT      = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data = '0;
   logic [2:0]  req_line_index = '0;
   logic        req_line_level = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_read_data;
   logic        rsp_rom_selected;
   logic        rsp_slot_forward;
   logic [2:0]  rsp_slot_index;
   logic        rsp_sub_int2_update;
   logic        rsp_sub_int2_level;
   logic        rsp_sub_comm_valid;
   logic        rsp_irq_line;
   int          fail_count;
   int          results_owed;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_request = 0;
   int hold_served = 0;
   int hold_left = 0;

   main_board_io_and_interrupt_glue uut (.*);

   board_glue_checker checker_inst (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_request) begin
         hold_served <= hold_request;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic item_type bus_item(input logic [2:0] action, input logic [15:0] address,
                                         input logic [7:0] data, input logic [2:0] line_index,
                                         input logic line_level);
      return {action, address, data, line_index, line_level};
   endfunction

   // Mostly decoded I/O pages and real sources, with some noise everywhere.
   function automatic item_type random_access();
      item_type it;
      int pick;
      pick = $urandom_range(99);
      it.address = 16'($urandom);
      it.data = 8'($urandom);
      it.line_index = 3'($urandom_range(SRC_D));
      if ($urandom_range(9) == 0) begin
         it.line_index = 3'($urandom_range(SRC_BEYOND, SRC_D + 1));
      end
      it.line_level = 1'($urandom);
      if (pick < 15) begin
         it.action = ACT_MEM_RD;
      end else if (pick < 42) begin
         it.action = ACT_IO_WR;
      end else if (pick < 56) begin
         it.action = ACT_IO_RD;
      end else if (pick < 76) begin
         it.action = ACT_IRQ;
      end else if (pick < 91) begin
         it.action = ACT_ACK;
      end else if (pick < 97) begin
         it.action = ACT_SUB;
      end else begin
         it.action = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
      end
      if ((it.action == ACT_IO_WR || it.action == ACT_IO_RD) && $urandom_range(9) < 8) begin
         it.address[15:8] = 8'hff;
      end
      return it;
   endfunction

   // Offers one item, after random idle cycles, and returns at its transfer.
   task automatic send_item(input item_type it);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do begin
            @(posedge clock);
         end while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_action <= it.action;
      req_address <= it.address;
      req_data <= it.data;
      req_line_index <= it.line_index;
      req_line_level <= it.line_level;
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // Sender pauses until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   initial begin
      int phase;
      int n;
      int waited;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: map edges, slot, map, mask, comm and ignore pages, mask writes, priorities, odd codes.
      send_item(bus_item(ACT_MEM_RD, 16'h0000, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_MEM_RD, 16'h8fff, 8'hff, SRC_A, 1'b1));
      send_item(bus_item(ACT_MEM_RD, 16'h9000, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_MEM_RD, 16'hffff, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_WR, 16'hff00, 8'hff, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_WR, 16'hffa0, 8'h03, SRC_S, 1'b0));
      send_item(bus_item(ACT_MEM_RD, 16'h0000, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_WR, 16'hffbf, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_WR, 16'hff80, 8'h9f, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_WR, 16'hff9f, 8'h9f, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_WR, 16'hffc0, 8'ha5, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_WR, 16'hffff, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_WR, 16'h0000, 8'hff, SRC_S, 1'b0));
      send_item(bus_item(ACT_SUB, 16'h0000, 8'h5a, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_RD, 16'hffff, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_IO_RD, 16'hff7f, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_IRQ, 16'h0000, 8'h00, SRC_D, 1'b1));
      send_item(bus_item(ACT_IRQ, 16'h0000, 8'h00, SRC_S, 1'b1));
      send_item(bus_item(ACT_IRQ, 16'h0000, 8'h00, SRC_BEYOND, 1'b1));
      send_item(bus_item(ACT_ACK, 16'h0000, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_ACK, 16'h0000, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_ACK, 16'h0000, 8'h00, SRC_S, 1'b0));
      send_item(bus_item(ACT_IRQ, 16'h0000, 8'h00, SRC_B, 1'b1));
      send_item(bus_item(ACT_IRQ, 16'h0000, 8'h00, SRC_B, 1'b0));
      send_item(bus_item(ACT_SPARE_LO, 16'hffff, 8'hff, SRC_S, 1'b1));
      send_item(bus_item(ACT_SPARE_HI, 16'h0000, 8'h00, SRC_S, 1'b0));
      drain();

      // Random traffic in four idling phases; the first also fills the block
      // behind a long receiver hold-off.
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct <= 0;
               hold_request <= hold_request + 1;
            end
            1: begin
               send_idle_pct = 64;
               stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct <= 64;
            end
            default: begin
               send_idle_pct = 11;
               stall_pct <= 11;
            end
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            send_item(random_access());
         end
         drain();
      end

      // Wait out the last results with a bound, then give the verdict.
      waited = 0;
      while (results_owed != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (results_owed != 0) begin
         $display("ERROR: %0d predicted results never arrived", results_owed);
      end
      if (fail_count == 0 && results_owed == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
